FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CHV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define CHV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/chv_pkg.sv
// Constants and elaboration-time helpers for the hyperbolic CORDIC vectoring block.
`default_nettype none

package chv_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 28;
  localparam int unsigned LAST_SHIFT_DEF = 28;

  // Width of the internal x, y and z datapath.
  localparam int unsigned IW = 64;

  // Shifts 4, 13 and 40 are run twice to keep the hyperbolic iteration convergent.
  function automatic bit is_repeat(input int unsigned sh);
    return (sh == 4) || (sh == 13) || (sh == 40);
  endfunction

  function automatic int unsigned num_steps(input int unsigned last_shift);
    int unsigned n;
    n = 0;
    for (int unsigned i = 1; i < 64; i++) begin
      if (i <= last_shift) begin
        n += is_repeat(i) ? 2 : 1;
      end
    end
    return n;
  endfunction

  // Shift amount used by iteration number s, counted from zero.
  function automatic int unsigned step_shift(input int unsigned s);
    int unsigned n;
    int unsigned res;
    n   = 0;
    res = 63;
    for (int unsigned i = 63; i >= 1; i--) begin
      n = 0;
      for (int unsigned j = 1; j < i; j++) begin
        n += is_repeat(j) ? 2 : 1;
      end
      if (s >= n && res == 63) begin
        res = i;
      end
    end
    return res;
  endfunction

  // atanh(2^-sh) from its series, rounded to frac fraction bits.
  function automatic logic [IW-1:0] atanh_rom(input int unsigned sh, input int unsigned frac);
    logic [IW-1:0] sum;
    int unsigned   e;
    int unsigned   d;
    sum = '0;
    d   = 62 - frac;
    for (int unsigned k = 0; k < 32; k++) begin
      if (sh * (2 * k + 1) <= 62) begin
        e   = 62 - sh * (2 * k + 1);
        sum = sum + ((64'd1 << e) / 64'(2 * k + 1));
      end
    end
    if (d == 0) begin
      return sum;
    end
    return (sum + (64'd1 << (d - 1))) >> d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/chv_if.sv
// Valid/ready channel interfaces for the input vectors and the results.
`default_nettype none

interface chv_in_if import chv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_start;
  logic signed [DATA_WIDTH-1:0] y_start;
  logic signed [DATA_WIDTH-1:0] z_start;

  modport source (output valid, output x_start, output y_start, output z_start,
                  input ready);
  modport sink (input valid, input x_start, input y_start, input z_start,
                output ready);
endinterface

interface chv_out_if import chv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_final;
  logic signed [DATA_WIDTH-1:0] y_final;
  logic signed [DATA_WIDTH-1:0] z_final;

  modport source (output valid, output x_final, output y_final, output z_final,
                  input ready);
  modport sink (input valid, input x_final, input y_final, input z_final,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/cordic_hyperbolic_vectoring.sv
// Hyperbolic CORDIC in vectoring mode: one fully unrolled pipeline stage per iteration.
//
// Usage: vectors (x_start, y_start, z_start) enter on in_ch and results
// (x_final, y_final, z_final) leave on out_ch; both are valid/ready channels and
// a transfer happens on a rising edge with valid and ready high.
// The datapath is an input register, one register stage per micro-rotation
// (NSTEP = LAST_SHIFT plus one for each of shifts 4, 13 and 40 in range, 30 by
// default) and an output register; each result passes through them in that order.
// Throughput is one vector per cycle while the skid register below is empty;
// each stage is a single 64-bit add/subtract for x, y and z in parallel.
// The whole pipeline advances together. A skid register behind the output
// register catches the one item that is in flight when the receiver stalls;
// in_ch.ready is low only while that skid register is occupied, and it comes
// straight from a flop.
// Reset (synchronous) empties the pipeline, the output and the skid register;
// there is no other state.
`default_nettype none

module cordic_hyperbolic_vectoring import chv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned LAST_SHIFT = LAST_SHIFT_DEF
) (
  input  wire        clk,
  input  wire        rst,
  chv_in_if.sink     in_ch,
  chv_out_if.source  out_ch
);

  localparam int unsigned NSTEP = num_steps(LAST_SHIFT);
  localparam logic signed [IW-1:0] WMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [IW-1:0] WMIN = ~WMAX;
  localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW - 1){1'b1}}};
  localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW - 1){1'b0}}};

  function automatic logic signed [IW-1:0] sat_add(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
    logic signed [IW-1:0] s;
    s = a + b;
    if (a[IW-1] == b[IW-1] && s[IW-1] != a[IW-1]) begin
      return a[IW-1] ? IMIN : IMAX;
    end
    return s;
  endfunction

  function automatic logic signed [IW-1:0] sat_sub(input logic signed [IW-1:0] a,
                                                   input logic signed [IW-1:0] b);
    logic signed [IW-1:0] s;
    s = a - b;
    if (a[IW-1] != b[IW-1] && s[IW-1] != a[IW-1]) begin
      return a[IW-1] ? IMIN : IMAX;
    end
    return s;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_out(input logic signed [IW-1:0] v);
    if (v > WMAX) begin
      return WMAX[DATA_WIDTH-1:0];
    end
    if (v < WMIN) begin
      return WMIN[DATA_WIDTH-1:0];
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  logic                 en;
  logic [NSTEP:0]       vr;
  logic signed [IW-1:0] xr [0:NSTEP];
  logic signed [IW-1:0] yr [0:NSTEP];
  logic signed [IW-1:0] zr [0:NSTEP];

  logic                         ov;
  logic signed [DATA_WIDTH-1:0] ox, oy, oz;
  logic                         sv;
  logic signed [DATA_WIDTH-1:0] sx, sy, sz;
  logic signed [DATA_WIDTH-1:0] fx, fy, fz;
  logic                         take;
  logic                         out_free;

  // The pipeline moves only while the skid register is empty.
  assign en          = !sv;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= '0;
    end else if (en) begin
      vr <= {vr[NSTEP-1:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[0] <= IW'(in_ch.x_start);
      yr[0] <= IW'(in_ch.y_start);
      zr[0] <= IW'(in_ch.z_start);
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    localparam int unsigned   SH  = step_shift(k - 1);
    localparam logic [IW-1:0] ANG = atanh_rom(SH, FRAC_BITS);

    logic signed [IW-1:0] xsh, ysh;
    logic                 same;
    logic signed [IW-1:0] x_next, y_next, z_next;

    always_comb begin
      xsh  = xr[k-1] >>> SH;
      ysh  = yr[k-1] >>> SH;
      same = (xr[k-1] == '0) || (yr[k-1] == '0) || (xr[k-1][IW-1] == yr[k-1][IW-1]);
      if (same) begin
        x_next = sat_sub(xr[k-1], ysh);
        y_next = sat_sub(yr[k-1], xsh);
        z_next = sat_add(zr[k-1], signed'(ANG));
      end else begin
        x_next = sat_add(xr[k-1], ysh);
        y_next = sat_add(yr[k-1], xsh);
        z_next = sat_sub(zr[k-1], signed'(ANG));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[k] <= x_next;
        yr[k] <= y_next;
        zr[k] <= z_next;
      end
    end
  end

  assign fx       = sat_out(xr[NSTEP]);
  assign fy       = sat_out(yr[NSTEP]);
  assign fz       = sat_out(zr[NSTEP]);
  assign take     = vr[NSTEP] && en;
  assign out_free = !ov || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (out_free) begin
      // The skid register is drained first; no new item arrives while it is full.
      ov <= sv || take;
      sv <= 1'b0;
    end else if (take) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sv) begin
        ox <= sx;
        oy <= sy;
        oz <= sz;
      end else begin
        ox <= fx;
        oy <= fy;
        oz <= fz;
      end
    end
    if (!out_free && take) begin
      sx <= fx;
      sy <= fy;
      sz <= fz;
    end
  end

  assign out_ch.valid   = ov;
  assign out_ch.x_final = ox;
  assign out_ch.y_final = oy;
  assign out_ch.z_final = oz;

endmodule

`default_nettype wire

FILE: rtl/chv_checker.sv
// Port-level checker for the hyperbolic CORDIC vectoring block, with its bind.
`default_nettype none
`include "assert_macros.svh"

module chv_checker import chv_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int unsigned LAST_SHIFT = LAST_SHIFT_DEF
) (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [DATA_WIDTH-1:0] x_final,
  input wire [DATA_WIDTH-1:0] y_final,
  input wire [DATA_WIDTH-1:0] z_final
);

  // Input register, iteration stages, output register and skid register.
  localparam int unsigned CAP = num_steps(LAST_SHIFT) + 3;
  localparam int unsigned CW  = $clog2(CAP + 1) + 1;

  logic [CW-1:0] cnt;
  logic          in_xfer;
  logic          out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Items accepted whose result has not been transferred yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_xfer && !out_xfer) begin
      cnt <= cnt + CW'(1);
    end else if (out_xfer && !in_xfer) begin
      cnt <= cnt - CW'(1);
    end
  end

  `CHV_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid right after reset")
  `CHV_ASSERT(a_no_invented, out_valid |-> (cnt != '0), "result without a pending input")
  `CHV_ASSERT(a_capacity, cnt <= CW'(CAP), "more items in flight than the pipeline holds")
  `CHV_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with output empty")
  `CHV_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> (out_valid && $stable(x_final) && $stable(y_final) && $stable(z_final)), "stalled result changed")

endmodule

bind cordic_hyperbolic_vectoring chv_checker #(
  .DATA_WIDTH (DATA_WIDTH),
  .LAST_SHIFT (LAST_SHIFT)
) u_chv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .x_final   (out_ch.x_final),
  .y_final   (out_ch.y_final),
  .z_final   (out_ch.z_final)
);

`default_nettype wire

FILE: tb/sv/chv_result_checker.sv
// Checker for the hyperbolic CORDIC block: predicts each result and compares it on transfer.
`timescale 1ns / 1ps

module chv_result_checker import chv_pkg::*; (
  input  logic clk,
  input  logic rst,
  chv_in_if    in_mon,
  chv_out_if   out_mon,
  output int   mismatch_count,
  output int   outstanding
);

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LS = LAST_SHIFT_DEF;

  // Shifts whose micro-rotation is applied twice.
  localparam int DOUBLED_SHIFT_A = 4;
  localparam int DOUBLED_SHIFT_B = 13;
  localparam int DOUBLED_SHIFT_C = 40;

  localparam logic signed [63:0] WIDE_MAX  = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] WIDE_MIN  = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] FIELD_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [63:0] FIELD_MIN = -(64'sd1 <<< (DW - 1));

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } triple_t;

  logic signed [63:0] atanh_lut [1:63];
  triple_t            expected_results [$];
  int                 fails;

  // atanh(2^-sh) as the odd power series, truncated per term, rounded to FB fraction bits.
  function automatic logic [63:0] atanh_step(input int sh);
    logic [63:0] acc;
    int          d;
    acc = '0;
    d   = 62 - FB;
    for (int odd = 1; sh * odd <= 62; odd += 2) begin
      acc += (64'd1 << (62 - sh * odd)) / 64'(odd);
    end
    if (d > 0) begin
      acc = (acc + (64'd1 << (d - 1))) >> d;
    end
    return acc;
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? WIDE_MIN : WIDE_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      return a[63] ? WIDE_MIN : WIDE_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [DW-1:0] clamp_field(input logic signed [63:0] v);
    if (v > FIELD_MAX) begin
      return FIELD_MAX[DW-1:0];
    end
    if (v < FIELD_MIN) begin
      return FIELD_MIN[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  function automatic triple_t hyperbolic_vectoring(input triple_t v);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    triple_t            r;
    int                 passes;
    bit                 agree;
    x = {{(64 - DW){v.x[DW-1]}}, v.x};
    y = {{(64 - DW){v.y[DW-1]}}, v.y};
    z = {{(64 - DW){v.z[DW-1]}}, v.z};
    for (int sh = 1; sh <= LS && sh < 64; sh++) begin
      passes = (sh == DOUBLED_SHIFT_A || sh == DOUBLED_SHIFT_B || sh == DOUBLED_SHIFT_C) ? 2 : 1;
      for (int p = 0; p < passes; p++) begin
        // A zero operand counts as agreeing in sign, so the rotation goes the same way.
        agree = (x == 0) || (y == 0) || (x[63] == y[63]);
        xs    = x >>> sh;
        ys    = y >>> sh;
        if (agree) begin
          x = sub_sat(x, ys);
          y = sub_sat(y, xs);
          z = add_sat(z, atanh_lut[sh]);
        end else begin
          x = add_sat(x, ys);
          y = add_sat(y, xs);
          z = sub_sat(z, atanh_lut[sh]);
        end
      end
    end
    r.x = clamp_field(x);
    r.y = clamp_field(y);
    r.z = clamp_field(z);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [DW-1:0] want,
                               input logic signed [DW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    for (int s = 1; s < 64; s++) begin
      atanh_lut[s] = atanh_step(s);
    end
  end

  always @(posedge clk) begin
    triple_t want;
    triple_t vec;
    if (rst) begin
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no vector outstanding: x=%0d y=%0d z=%0d",
                 out_mon.x_final, out_mon.y_final, out_mon.z_final);
          fails++;
        end else begin
          want = expected_results.pop_front();
          compare_field("x_final", want.x, out_mon.x_final);
          compare_field("y_final", want.y, out_mon.y_final);
          compare_field("z_final", want.z, out_mon.z_final);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        vec.x = in_mon.x_start;
        vec.y = in_mon.y_start;
        vec.z = in_mon.z_start;
        expected_results.push_back(hyperbolic_vectoring(vec));
      end
    end
    outstanding    <= expected_results.size();
    mismatch_count <= fails;
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the hyperbolic CORDIC testbench: clock, reset, vector stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import chv_pkg::*;

  localparam int DW           = DATA_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1430;
  localparam int HOLD_AT      = 500;
  localparam int PAUSE_AT     = 900;
  localparam int HOLD_CYCLES  = 200;
  localparam int FLUSH_CYCLES = 48;
  localparam int STALL_LIMIT  = 2000;

  localparam logic signed [DW-1:0] MAX_WORD = {1'b0, {(DW - 1){1'b1}}};
  localparam logic signed [DW-1:0] MIN_WORD = {1'b1, {(DW - 1){1'b0}}};
  localparam logic signed [DW-1:0] ONE      = DW'(1) <<< FRAC_BITS_DEF;
  localparam logic signed [DW-1:0] HALF     = DW'(1) <<< (FRAC_BITS_DEF - 1);

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } vec_t;

  bit   clk = 1'b0;
  logic rst;
  bit   hold_toggle = 1'b0;
  int   mismatch_count;
  int   outstanding;

  chv_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  chv_out_if #(.DATA_WIDTH(DW)) out_ch ();

  cordic_hyperbolic_vectoring DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  chv_result_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #1 clk = ~clk;

  function automatic vec_t make_vec(input logic signed [DW-1:0] x,
                                    input logic signed [DW-1:0] y,
                                    input logic signed [DW-1:0] z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic logic signed [DW-1:0] corner_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MAX_WORD;
      2: return MIN_WORD;
      3: return ONE;
      4: return -ONE;
      5: return 1;
      6: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_t random_vector();
    vec_t   v;
    longint mag;
    int     ratio;
    int     kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // Convergent vector: |y| stays below |x| and magnitudes span many octaves.
      mag = longint'($urandom_range(1, 32'h3FFF_FFFF) >> $urandom_range(0, 24));
      if (mag == 0) begin
        mag = 1;
      end
      if ($urandom_range(0, 1) == 1) begin
        mag = -mag;
      end
      ratio = int'($urandom_range(0, 1900)) - 950;
      v.x   = mag[DW-1:0];
      v.y   = DW'((mag * ratio) / 1000);
      v.z   = $signed($urandom) >>> $urandom_range(0, 31);
    end else if (kind < 8) begin
      v.x = $urandom;
      v.y = $urandom;
      v.z = $urandom;
    end else if (kind == 8) begin
      v.x = corner_word();
      v.y = corner_word();
      v.z = corner_word();
    end else begin
      v.x = DW'(int'($urandom_range(0, 64)) - 32);
      v.y = DW'(int'($urandom_range(0, 64)) - 32);
      v.z = DW'(int'($urandom_range(0, 64)) - 32);
    end
    return v;
  endfunction

  // Valid stays high from one item to the next inside a burst.
  task automatic send_vector(input vec_t v);
    in_ch.valid   <= 1'b1;
    in_ch.x_start <= v.x;
    in_ch.y_start <= v.y;
    in_ch.z_start <= v.z;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Receiver: switches among random stall patterns at random intervals, and on request
  // holds off for a long stretch so the pipeline fills and backs up the input.
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_left;
    int cyc;
    bit seen_toggle;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    cyc = 0;
    seen_toggle = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left   = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= (cyc % 4 != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int burst;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.x_start = '0;
    in_ch.y_start = '0;
    in_ch.z_start = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Zero vector, field extremes, non-convergent and saturating inputs.
    send_vector(make_vec('0, '0, '0));
    send_vector(make_vec(MAX_WORD, '0, '0));
    send_vector(make_vec(MIN_WORD, '0, '0));
    send_vector(make_vec(MAX_WORD, MAX_WORD, MAX_WORD));
    send_vector(make_vec(MIN_WORD, MIN_WORD, MIN_WORD));
    send_vector(make_vec(MAX_WORD, MIN_WORD, MIN_WORD));
    send_vector(make_vec(MIN_WORD, MAX_WORD, MAX_WORD));
    send_vector(make_vec('0, MAX_WORD, '0));
    send_vector(make_vec('0, MIN_WORD, '0));
    send_vector(make_vec(-1, -1, -1));
    send_vector(make_vec(1, 0, 0));
    send_vector(make_vec(ONE, HALF, '0));
    send_vector(make_vec(ONE, -HALF, '0));
    send_vector(make_vec(-ONE, HALF, '0));
    send_vector(make_vec(-ONE, -HALF, ONE));
    send_vector(make_vec(2 * ONE, ONE, -ONE));
    send_vector(make_vec(ONE, ONE, '0));
    send_vector(make_vec(HALF, 2 * ONE, '0));
    send_vector(make_vec(-HALF, -2 * ONE, MAX_WORD));
    send_vector(make_vec(MAX_WORD, MAX_WORD - 1, MIN_WORD));
    wait_all_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == HOLD_AT) begin
        // Long receiver hold while the sender keeps offering back to back.
        hold_toggle = ~hold_toggle;
        for (int b = 0; b < 120; b++) begin
          send_vector(random_vector());
          sent++;
        end
      end
      if (sent == PAUSE_AT) begin
        wait_all_results();
        // Restart with one vector into the drained pipeline.
        send_vector(random_vector());
        sent++;
      end
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS && sent != HOLD_AT
           && sent != PAUSE_AT; b++) begin
        send_vector(random_vector());
        sent++;
      end
      sender_gap(($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3));
    end

    wait_all_results();
    repeat (FLUSH_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
